// ===== hw/rtl/tls_pkg.sv =====
package tls_pkg;

	// Field widths.
	localparam int PERIOD_W = 22;
	localparam int HALF_W = 16;
	localparam int ELAPSED_W = 24;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 22;
	localparam int CMD_W = 2;
	localparam int MODE_W = 2;

	// Default number of half-period expiries spent in blinking green.
	localparam int BLINK_EXPIRIES_DEF = 6;

	// Red lasts four base periods unless shortened (a shift by this many bits).
	localparam int RED_SHIFT = 2;

	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};

	// Configuration register reset values.
	localparam logic [PERIOD_W-1:0] BASE_RST = PERIOD_W'(5000);
	localparam logic [PERIOD_W-1:0] YELLOW_RST = PERIOD_W'(3000);
	localparam logic [HALF_W-1:0] HALF_RST = HALF_W'(500);

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_BASE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_YELLOW = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HALF = 2'd2;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
	localparam logic [CMD_W-1:0] CMD_MODE_NORMAL = 2'd1;
	localparam logic [CMD_W-1:0] CMD_MODE_SHORT = 2'd2;

	// Reported mode numbers.
	localparam logic [MODE_W-1:0] MODE_NORMAL = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SHORT = 2'd2;

	typedef enum logic [1:0] {
		PH_RED = 2'd0,
		PH_GREEN = 2'd1,
		PH_BLINK = 2'd2,
		PH_YELLOW = 2'd3
	} phase_t;

	typedef struct packed {
		logic [PERIOD_W-1:0] base_period;
		logic [PERIOD_W-1:0] yellow_period;
		logic [HALF_W-1:0] blink_half;
	} cfg_t;

	// Packed with the red lamp in the lowest bit.
	typedef struct packed {
		logic [MODE_W-1:0] mode_report;
		phase_t phase;
		logic green_lamp;
		logic yellow_lamp;
		logic red_lamp;
	} res_t;

endpackage

// ===== hw/rtl/tls_cfg_regs.sv =====
module tls_cfg_regs (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input logic [tls_pkg::CFG_IDX_W-1:0] wr_index,
	input logic [tls_pkg::CFG_DATA_W-1:0] wr_data,
	output tls_pkg::cfg_t cfg
);
	import tls_pkg::*;

	logic [PERIOD_W-1:0] base_q;
	logic [PERIOD_W-1:0] yellow_q;
	logic [HALF_W-1:0] half_q;

	// Register file; an index past the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_RST;
			yellow_q <= YELLOW_RST;
			half_q <= HALF_RST;
		end else if (wr_en) begin
			if (wr_index == CFG_BASE) begin
				base_q <= wr_data[PERIOD_W-1:0];
			end
			if (wr_index == CFG_YELLOW) begin
				yellow_q <= wr_data[PERIOD_W-1:0];
			end
			if (wr_index == CFG_HALF) begin
				half_q <= wr_data[HALF_W-1:0];
			end
		end
	end

	assign cfg.base_period = base_q;
	assign cfg.yellow_period = yellow_q;
	assign cfg.blink_half = half_q;

endmodule

// ===== hw/rtl/tls_core.sv =====
module tls_core #(
	parameter int BLINK_EXPIRIES = tls_pkg::BLINK_EXPIRIES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic accept,
	input logic [tls_pkg::CMD_W-1:0] cmd,
	input logic button_pressed,
	input tls_pkg::cfg_t cfg,
	output tls_pkg::res_t res
);
	import tls_pkg::*;

	localparam int CntW = (BLINK_EXPIRIES > 2) ? $clog2(BLINK_EXPIRIES) : 1;

	phase_t phase_q, phase_d;
	logic [ELAPSED_W-1:0] elapsed_q, elapsed_d;
	logic shortened_q, shortened_d;
	logic [CntW-1:0] blink_cnt_q, blink_cnt_d;
	logic level_q, level_d;

	logic [ELAPSED_W-1:0] elapsed_adv;
	logic short_cmd;
	logic short_red;
	logic [ELAPSED_W-1:0] red_time;
	logic [CntW:0] cnt_inc;

	// Command and tick applied before the phase timer is compared.
	always_comb begin
		elapsed_adv = elapsed_q;
		short_cmd = shortened_q;
		unique case (cmd)
			CMD_TICK: begin
				if (elapsed_q != ELAPSED_MAX) begin
					elapsed_adv = elapsed_q + ELAPSED_W'(1);
				end
			end
			CMD_MODE_NORMAL: short_cmd = 1'b0;
			CMD_MODE_SHORT: short_cmd = 1'b1;
			default: begin
			end
		endcase
	end

	assign short_red = short_cmd | button_pressed;
	assign red_time = short_red ? {2'b00, cfg.base_period}
		: {cfg.base_period, RED_SHIFT'(0)};
	assign cnt_inc = {1'b0, blink_cnt_q} + (CntW + 1)'(1);

	// Next state: at most one phase change per item.
	always_comb begin
		phase_d = phase_q;
		elapsed_d = elapsed_adv;
		shortened_d = short_cmd;
		blink_cnt_d = blink_cnt_q;
		level_d = level_q;
		unique case (phase_q)
			PH_RED: begin
				shortened_d = short_red;
				if (elapsed_adv >= red_time) begin
					shortened_d = 1'b0;
					phase_d = PH_GREEN;
					elapsed_d = '0;
				end
			end
			PH_GREEN: begin
				if (elapsed_adv >= {2'b00, cfg.base_period}) begin
					level_d = 1'b0;
					phase_d = PH_BLINK;
					elapsed_d = '0;
				end
			end
			PH_BLINK: begin
				if (elapsed_adv >= {8'h00, cfg.blink_half}) begin
					elapsed_d = '0;
					if (cnt_inc < (CntW + 1)'(BLINK_EXPIRIES)) begin
						blink_cnt_d = cnt_inc[CntW-1:0];
						level_d = ~level_q;
					end else begin
						blink_cnt_d = '0;
						level_d = 1'b0;
						phase_d = PH_YELLOW;
					end
				end
			end
			PH_YELLOW: begin
				if (elapsed_adv >= {2'b00, cfg.yellow_period}) begin
					phase_d = PH_RED;
					elapsed_d = '0;
				end
			end
			default: begin
			end
		endcase
	end

	// Result fields, taken from the state after the item.
	always_comb begin
		res.red_lamp = (phase_d == PH_RED);
		res.yellow_lamp = (phase_d == PH_YELLOW);
		res.green_lamp = (phase_d == PH_GREEN) || ((phase_d == PH_BLINK) && level_d);
		res.phase = phase_d;
		res.mode_report = ((phase_d == PH_RED) && !shortened_d) ? MODE_NORMAL : MODE_SHORT;
	end

	// Sequencer state, updated once per accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_RED;
			elapsed_q <= '0;
			shortened_q <= 1'b0;
			blink_cnt_q <= '0;
			level_q <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			elapsed_q <= elapsed_d;
			shortened_q <= shortened_d;
			blink_cnt_q <= blink_cnt_d;
			level_q <= level_d;
		end
	end

endmodule

// ===== hw/rtl/tls_out_buf.sv =====
module tls_out_buf (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input tls_pkg::res_t in_res,
	output logic out_valid,
	input logic out_ready,
	output tls_pkg::res_t out_res
);
	import tls_pkg::*;

	logic main_valid_q, skid_valid_q;
	res_t main_q, skid_q;
	logic push, pop;

	assign in_ready = !skid_valid_q;
	assign push = in_valid && in_ready;
	assign pop = main_valid_q && out_ready;

	// Valid flags of the output register and its skid entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!main_valid_q || pop) begin
			main_valid_q <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Payload moves in arrival order: skid entry first, then the new beat.
	always_ff @(posedge clk) begin
		if (!main_valid_q || pop) begin
			if (skid_valid_q) begin
				main_q <= skid_q;
			end else if (push) begin
				main_q <= in_res;
			end
		end else if (push) begin
			skid_q <= in_res;
		end
	end

	assign out_valid = main_valid_q;
	assign out_res = main_q;

endmodule

// ===== hw/rtl/traffic_light_sequencer.sv =====
// Traffic light sequencer: red, green, blinking green, yellow, timed by tick beats on the
// slave stream (tuser 0 is a one-ms tick, 1 selects normal red, 2 short red). Every input
// beat is applied to the sequencer in the cycle it is accepted and yields exactly one result
// beat, held in the output buffer, so the block takes one item per clock while s_tready is
// high; the sequencer state update is a single pass of compare and increment logic. A
// two-entry output register keeps s_tready high until two results wait unread on the master
// side. Configuration writes are accepted in every cycle and take effect once registered.
module traffic_light_sequencer #(
	parameter int BLINK_EXPIRIES = tls_pkg::BLINK_EXPIRIES_DEF
) (
	input logic clk,
	input logic arst_n,
	// Slave stream.
	input logic s_tvalid,
	output logic s_tready,
	input logic [7:0] s_tdata,  // [0] button_pressed, [7:1] zero
	input logic [1:0] s_tuser,  // [1:0] cmd
	// Master stream.
	output logic m_tvalid,
	input logic m_tready,
	output logic [7:0] m_tdata,  // [0] red_lamp, [1] yellow_lamp, [2] green_lamp,
	                             // [4:3] phase, [6:5] mode_report, [7] zero
	// Configuration writes.
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [tls_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [tls_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tls_pkg::*;

	cfg_t cfg;
	res_t core_res, out_res;
	logic accept;

	assign cfg_ready = 1'b1;
	assign accept = s_tvalid && s_tready;

	tls_cfg_regs u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(cfg_valid && cfg_ready),
		.wr_index(cfg_index),
		.wr_data(cfg_data),
		.cfg(cfg)
	);

	tls_core #(
		.BLINK_EXPIRIES(BLINK_EXPIRIES)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.cmd(s_tuser),
		.button_pressed(s_tdata[0]),
		.cfg(cfg),
		.res(core_res)
	);

	tls_out_buf u_out (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_res(core_res),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_res(out_res)
	);

	assign m_tdata = {1'b0, out_res};

endmodule

// ===== hw/rtl/tls_checker.sv =====
module tls_checker (
	input logic clk,
	input logic arst_n,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic [7:0] m_tdata
);
	import tls_pkg::*;

	// A stalled result beat holds its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// The red lamp is lit exactly in the red phase.
	a_red: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[0] == (m_tdata[4:3] == PH_RED))
		else $error("red lamp disagrees with phase");

	// The yellow lamp is lit exactly in the yellow phase, and never with green.
	a_yellow: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[1] == (m_tdata[4:3] == PH_YELLOW)
			&& !(m_tdata[1] && m_tdata[2]))
		else $error("yellow lamp disagrees with phase");

	// Outside red the mode always reads as short; in red it is one or two.
	a_mode: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[6:5] == MODE_SHORT)
			|| (m_tdata[6:5] == MODE_NORMAL && m_tdata[4:3] == PH_RED))
		else $error("bad mode report");

	// Input backpressure only when a result is waiting.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no pending result");

endmodule

bind traffic_light_sequencer tls_checker u_tls_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata)
);

// ===== sim/traffic_light_sequencer_tb.sv =====
module traffic_light_sequencer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tls_pkg::*;

	localparam int BLINK_EXPIRIES = BLINK_EXPIRIES_DEF;
	localparam int QUIET_LIMIT = 2000;
	localparam int LAP_BEATS = 200;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam logic [PERIOD_W-1:0] PERIOD_MAX = '1;
	localparam logic [HALF_W-1:0] HALF_MAX = '1;

	typedef enum {ROW_BEAT, ROW_TIMING} row_kind_t;

	typedef struct {
		row_kind_t kind;
		logic [CMD_W-1:0] cmd;
		logic btn;
		bit known;
		res_t want;
		logic [PERIOD_W-1:0] base;
		logic [PERIOD_W-1:0] yellow;
		logic [HALF_W-1:0] half;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = 8'd0;
	logic [1:0] s_tuser = CMD_TICK;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_BASE;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Light state as predicted from the accepted beats.
	phase_t lt_phase = PH_RED;
	logic [ELAPSED_W-1:0] lt_elapsed = '0;
	logic lt_short = 1'b0;
	logic [3:0] lt_blinks = '0;
	logic lt_level = 1'b0;
	logic [PERIOD_W-1:0] cur_base = BASE_RST;
	logic [PERIOD_W-1:0] cur_yellow = YELLOW_RST;
	logic [HALF_W-1:0] cur_half = HALF_RST;

	res_t lamp_q[$];
	plan_row_t plan[$];
	int idle_pct = 0;
	int stall_pct = 0;
	int fail_cnt = 0;
	int beats_sent = 0;
	int results_seen = 0;
	int cfg_writes = 0;
	int red_returns = 0;
	int quiet_cycles = 0;

	traffic_light_sequencer #(
		.BLINK_EXPIRIES(BLINK_EXPIRIES)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Apply one command beat to the predicted lights and return the lamp report.
	function automatic res_t advance_lights(input logic [CMD_W-1:0] c, input logic b);
		logic [ELAPSED_W+1:0] red_limit;
		res_t r;
		case (c)
			CMD_TICK: if (lt_elapsed != ELAPSED_MAX) lt_elapsed++;
			CMD_MODE_NORMAL: lt_short = 1'b0;
			CMD_MODE_SHORT: lt_short = 1'b1;
			default: ;
		endcase
		case (lt_phase)
			PH_RED: begin
				// The button only cuts red short; it never lengthens it again.
				if (b)
					lt_short = 1'b1;
				red_limit = lt_short ? (ELAPSED_W+2)'(cur_base)
					: (ELAPSED_W+2)'(cur_base) << RED_SHIFT;
				if ((ELAPSED_W+2)'(lt_elapsed) >= red_limit) begin
					lt_short = 1'b0;
					lt_phase = PH_GREEN;
					lt_elapsed = '0;
				end
			end
			PH_GREEN: if (lt_elapsed >= cur_base) begin
				lt_level = 1'b0;
				lt_phase = PH_BLINK;
				lt_elapsed = '0;
			end
			PH_BLINK: if (lt_elapsed >= cur_half) begin
				lt_blinks++;
				lt_elapsed = '0;
				if (lt_blinks < BLINK_EXPIRIES) begin
					lt_level = !lt_level;
				end else begin
					lt_blinks = '0;
					lt_level = 1'b0;
					lt_phase = PH_YELLOW;
				end
			end
			default: if (lt_elapsed >= cur_yellow) begin
				lt_phase = PH_RED;
				lt_elapsed = '0;
				red_returns++;
			end
		endcase
		r.red_lamp = (lt_phase == PH_RED);
		r.yellow_lamp = (lt_phase == PH_YELLOW);
		r.green_lamp = (lt_phase == PH_GREEN) || (lt_phase == PH_BLINK && lt_level);
		r.phase = lt_phase;
		r.mode_report = (lt_phase == PH_RED && !lt_short) ? MODE_NORMAL : MODE_SHORT;
		return r;
	endfunction

	function automatic plan_row_t beat_row(input logic [CMD_W-1:0] c, input logic b);
		plan_row_t r;
		r.kind = ROW_BEAT;
		r.cmd = c;
		r.btn = b;
		r.known = 1'b0;
		r.want = '0;
		return r;
	endfunction

	// A beat whose report is plain red with the given mode number.
	function automatic plan_row_t red_row(input logic [CMD_W-1:0] c, input logic b,
			input logic [MODE_W-1:0] m);
		plan_row_t r;
		r = beat_row(c, b);
		r.known = 1'b1;
		r.want = '{mode_report: m, phase: PH_RED, green_lamp: 1'b0, yellow_lamp: 1'b0,
			red_lamp: 1'b1};
		return r;
	endfunction

	function automatic plan_row_t timing_row(input logic [PERIOD_W-1:0] b,
			input logic [PERIOD_W-1:0] y, input logic [HALF_W-1:0] h);
		plan_row_t r;
		r.kind = ROW_TIMING;
		r.base = b;
		r.yellow = y;
		r.half = h;
		return r;
	endfunction

	// Offer one beat, wait for it to be taken, then maybe leave a gap.
	task automatic send_beat(input logic [CMD_W-1:0] c, input logic b, input bit known,
			input res_t typed);
		res_t model;
		s_tvalid <= 1'b1;
		s_tuser <= c;
		s_tdata <= {7'd0, b};
		do @(posedge clk); while (!s_tready);
		model = advance_lights(c, b);
		lamp_q.push_back(known ? typed : model);
		beats_sent++;
		if ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
	endtask

	// Hold off the sender until every lamp report has been read back.
	task automatic drain_reports();
		s_tvalid <= 1'b0;
		while (lamp_q.size() != 0)
			@(posedge clk);
	endtask

	// Write all three timing registers back to back.
	task automatic write_timing(input logic [PERIOD_W-1:0] b, input logic [PERIOD_W-1:0] y,
			input logic [HALF_W-1:0] h);
		logic [CFG_IDX_W-1:0] idx_list[3];
		logic [CFG_DATA_W-1:0] val_list[3];
		idx_list = '{CFG_BASE, CFG_YELLOW, CFG_HALF};
		val_list = '{b, y, CFG_DATA_W'(h)};
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx_list[i];
			cfg_data <= val_list[i];
			do @(posedge clk); while (!cfg_ready);
			case (idx_list[i])
				CFG_BASE: cur_base = b;
				CFG_YELLOW: cur_yellow = y;
				default: cur_half = h;
			endcase
			cfg_writes++;
		end
		cfg_valid <= 1'b0;
	endtask

	function automatic void check_field(input string name, input logic [1:0] want,
			input logic [1:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			fail_cnt++;
		end
	endfunction

	// Receiver: stall at random with the current pressure.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	// Compare each result beat with the oldest predicted report.
	always @(posedge clk) begin : report_check
		res_t got;
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = res_t'(m_tdata[6:0]);
			results_seen++;
			if (lamp_q.size() == 0) begin
				$error("result beat %h arrived with no report pending", m_tdata);
				fail_cnt++;
			end else begin
				want = lamp_q.pop_front();
				check_field("red_lamp", want.red_lamp, got.red_lamp);
				check_field("yellow_lamp", want.yellow_lamp, got.yellow_lamp);
				check_field("green_lamp", want.green_lamp, got.green_lamp);
				check_field("phase", want.phase, got.phase);
				check_field("mode_report", want.mode_report, got.mode_report);
			end
		end
	end

	// Give up when no beat moves on any channel for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		int idle_tab[3];
		int stall_tab[3];
		int sent_in_lap;
		int seg;
		int pick;
		logic [CMD_W-1:0] c;
		logic b;
		logic [PERIOD_W-1:0] nb;
		logic [PERIOD_W-1:0] ny;
		logic [HALF_W-1:0] nh;

		idle_tab = '{8, 85, 0};
		stall_tab = '{85, 8, 0};

		// Directed part: reset timing first, then zero, maximum and small timing.
		plan.push_back(red_row(CMD_TICK, 1'b0, MODE_NORMAL));
		plan.push_back(red_row(CMD_UNUSED, 1'b0, MODE_NORMAL));
		plan.push_back(red_row(CMD_TICK, 1'b1, MODE_SHORT));
		plan.push_back(red_row(CMD_MODE_NORMAL, 1'b0, MODE_NORMAL));
		plan.push_back(red_row(CMD_MODE_SHORT, 1'b0, MODE_SHORT));
		plan.push_back(red_row(CMD_MODE_NORMAL, 1'b1, MODE_SHORT));
		// Zero durations expire on every beat, so this walks the whole cycle.
		plan.push_back(timing_row('0, '0, '0));
		plan.push_back(beat_row(CMD_UNUSED, 1'b0));
		plan.push_back(beat_row(CMD_TICK, 1'b1));
		plan.push_back(beat_row(CMD_MODE_SHORT, 1'b1));
		plan.push_back(beat_row(CMD_TICK, 1'b0));
		plan.push_back(beat_row(CMD_UNUSED, 1'b1));
		plan.push_back(beat_row(CMD_TICK, 1'b0));
		plan.push_back(beat_row(CMD_MODE_NORMAL, 1'b0));
		plan.push_back(beat_row(CMD_TICK, 1'b1));
		plan.push_back(beat_row(CMD_TICK, 1'b0));
		// Longest timing holds red; shrinking it mid-phase must end red at once.
		plan.push_back(timing_row(PERIOD_MAX, PERIOD_MAX, HALF_MAX));
		plan.push_back(beat_row(CMD_TICK, 1'b0));
		plan.push_back(beat_row(CMD_MODE_SHORT, 1'b1));
		plan.push_back(beat_row(CMD_TICK, 1'b1));
		plan.push_back(timing_row(PERIOD_W'(2), PERIOD_W'(1), HALF_W'(1)));
		plan.push_back(beat_row(CMD_UNUSED, 1'b0));
		plan.push_back(beat_row(CMD_MODE_SHORT, 1'b0));
		plan.push_back(beat_row(CMD_TICK, 1'b1));
		plan.push_back(beat_row(CMD_TICK, 1'b0));
		plan.push_back(beat_row(CMD_TICK, 1'b0));
		plan.push_back(beat_row(CMD_TICK, 1'b0));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_pct = idle_tab[0];
		stall_pct = stall_tab[0];
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_TIMING) begin
				drain_reports();
				write_timing(plan[i].base, plan[i].yellow, plan[i].half);
			end else begin
				send_beat(plan[i].cmd, plan[i].btn, plan[i].known, plan[i].want);
			end
		end

		// Random part: segments of beats, each under a freshly chosen timing.
		for (int lap = 0; lap < 3; lap++) begin
			idle_pct = idle_tab[lap];
			stall_pct = stall_tab[lap];
			sent_in_lap = 0;
			while (sent_in_lap < LAP_BEATS) begin
				drain_reports();
				nb = PERIOD_W'($urandom_range(6));
				ny = PERIOD_W'($urandom_range(5));
				nh = HALF_W'($urandom_range(3));
				case ($urandom_range(9))
					0: nb = PERIOD_MAX;
					1: ny = PERIOD_MAX;
					2: nh = HALF_MAX;
					3: begin
						nb = '0;
						ny = '0;
						nh = '0;
					end
					default: ;
				endcase
				write_timing(nb, ny, nh);
				seg = $urandom_range(60, 20);
				repeat (seg) begin
					pick = $urandom_range(99);
					c = (pick < 72) ? CMD_TICK
						: (pick < 84) ? CMD_MODE_NORMAL
						: (pick < 95) ? CMD_MODE_SHORT : CMD_UNUSED;
					b = ($urandom_range(99) < 15);
					send_beat(c, b, 1'b0, '0);
					sent_in_lap++;
				end
			end
		end

		drain_reports();
		repeat (8) @(posedge clk);

		$display("Sent %0d command beats and checked %0d lamp reports under %0d register writes.",
			beats_sent, results_seen, cfg_writes);
		$display("The lights went all the way around %0d times; %0d mismatches were seen.",
			red_returns, fail_cnt);
		if (fail_cnt == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
